@@ design/pst_pkg.sv @@
// Shared types and constants for the polyline stroke tessellator.
package pst_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [15:0] HALF_WIDTH_RST = 16'd256;
	localparam logic        SQUARE_CAP_RST = 1'b0;

	// register index, taken from paddr[2]
	localparam logic REG_HALF_WIDTH = 1'b0;
	localparam logic REG_SQUARE_CAP = 1'b1;

	typedef enum logic [1:0] {
		KIND_CAP    = 2'd0,
		KIND_CORNER = 2'd1,
		KIND_STITCH = 2'd2
	} vkind_t;

	typedef struct packed {
		logic seg;   // point closes a segment
		logic zl;    // segment has zero length
		logic stk;   // stroke start, empties the strip
	} job_flags_t;

	localparam int JOB_FLAGS_W = $bits(job_flags_t);

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CAP,
		BK_NORM,
		BK_SQ,
		BK_SQRT,
		BK_DIV,
		BK_SCALE,
		BK_CORNER,
		BK_EMIT
	} back_state_t;

endpackage

@@ design/pst_front.sv @@
// Front end: accepts points, tracks the previous point, classifies segments.
module pst_front import pst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         subpath_start,
	input  logic                         stroke_start,
	input  logic                         q_full,
	output logic                         q_push,
	output job_flags_t                   job_flags,
	output logic signed [COORD_BITS-1:0] job_x1,
	output logic signed [COORD_BITS-1:0] job_y1,
	output logic signed [COORD_BITS-1:0] job_x2,
	output logic signed [COORD_BITS-1:0] job_y2,
	output logic signed [COORD_BITS:0]   job_dx,
	output logic signed [COORD_BITS:0]   job_dy
);

	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                         have_prev_q;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		job_x1 = prev_x_q;
		job_y1 = prev_y_q;
		job_x2 = point_x;
		job_y2 = point_y;
		job_dx = (COORD_BITS+1)'(point_x) - (COORD_BITS+1)'(prev_x_q);
		job_dy = (COORD_BITS+1)'(point_y) - (COORD_BITS+1)'(prev_y_q);
		job_flags.seg = have_prev_q && !subpath_start && !stroke_start;
		job_flags.zl  = job_flags.seg && (job_dx == '0) && (job_dy == '0);
		job_flags.stk = stroke_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (q_push) begin
			prev_x_q    <= point_x;
			prev_y_q    <= point_y;
			have_prev_q <= 1'b1;
		end
	end

endmodule

@@ design/pst_queue.sv @@
// Short job queue between front and back ends.
module pst_queue import pst_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/pst_back.sv @@
// Back end: normalizes the segment, root and divide, emits vertices.
module pst_back import pst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [15:0]                  half_width,
	input  logic                         square_cap,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  job_flags_t                   job_flags,
	input  logic signed [COORD_BITS-1:0] job_x1,
	input  logic signed [COORD_BITS-1:0] job_y1,
	input  logic signed [COORD_BITS-1:0] job_x2,
	input  logic signed [COORD_BITS-1:0] job_y2,
	input  logic signed [COORD_BITS:0]   job_dx,
	input  logic signed [COORD_BITS:0]   job_dy,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic [1:0]                   vertex_kind,
	output logic                         zero_length,
	output logic                         last_of_run
);

	localparam int MAG_W = COORD_BITS + 1;
	localparam int SHIFT = 23 - FRAC_BITS;
	localparam int OFF_W = 34 - SHIFT;
	localparam int SUM_W = ((COORD_BITS > OFF_W + 1) ? COORD_BITS : OFF_W + 1) + 2;
	localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > MAXV) c = MAXV;
		if (v < MINV) c = MINV;
		return c[COORD_BITS-1:0];
	endfunction

	back_state_t state_q, state_d;

	job_flags_t                   flags_q;
	logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
	logic                         sx_q, sy_q;
	logic [MAG_W-1:0]             ax_q, ay_q;
	logic                         strip_q;
	logic signed [COORD_BITS-1:0] lsx_q, lsy_q;
	logic [63:0]                  v_q, r_q;
	logic [4:0]                   cnt_q;
	logic [31:0]                  n_q;
	logic [46:0]                  remx_q, remy_q;
	logic [16:0]                  ux_q, uy_q;
	logic signed [OFF_W:0]        co_q, so_q;
	logic signed [COORD_BITS-1:0] cax_q, cay_q, cbx_q, cby_q, ccx_q, ccy_q, cdx_q, cdy_q;
	logic [2:0]                   emit_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] vx_q, vy_q;
	logic [1:0]                   vk_q;
	logic                         zl_q, last_q;

	logic                         can_load, load;
	logic signed [COORD_BITS-1:0] ld_x, ld_y;
	vkind_t                       ld_kind;
	logic                         ld_last;

	logic [63:0]       ax64, ay64, bitv, sq_t;
	logic              big, low_mag, sq_ge;
	logic [48:0]       dsub;
	logic              gex, gey;
	logic [33:0]       px, py;
	logic [OFF_W-1:0]  magx, magy;
	logic signed [SUM_W-1:0] x1w, y1w, x2w, y2w, cow, sow, ecw, esw;

	assign can_load = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == BK_IDLE) && q_valid;

	// datapath helpers
	always_comb begin
		ax64    = 64'(ax_q);
		ay64    = 64'(ay_q);
		big     = (ax64 >= 64'd65536) || (ay64 >= 64'd65536);
		low_mag = (ax64 < 64'd32768) && (ay64 < 64'd32768);
		bitv    = 64'd1 << (6'd62 - {cnt_q, 1'b0});
		sq_t    = r_q + bitv;
		sq_ge   = v_q >= sq_t;
		dsub    = 49'(n_q) << cnt_q;
		gex     = 49'(remx_q) >= dsub;
		gey     = 49'(remy_q) >= dsub;
		px      = 34'(ux_q) * 34'(half_width) + (34'd1 << (SHIFT - 1));
		py      = 34'(uy_q) * 34'(half_width) + (34'd1 << (SHIFT - 1));
		magx    = OFF_W'(px >> SHIFT);
		magy    = OFF_W'(py >> SHIFT);
		x1w     = SUM_W'(x1_q);
		y1w     = SUM_W'(y1_q);
		x2w     = SUM_W'(x2_q);
		y2w     = SUM_W'(y2_q);
		cow     = SUM_W'(co_q);
		sow     = SUM_W'(so_q);
		ecw     = square_cap ? cow : '0;
		esw     = square_cap ? sow : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:   if (q_valid) state_d = BK_CAP;
			BK_CAP: begin
				if (can_load) begin
					if (!flags_q.seg) state_d = BK_IDLE;
					else if (flags_q.zl) state_d = BK_CORNER;
					else state_d = BK_NORM;
				end
			end
			BK_NORM:   if (!big && !low_mag) state_d = BK_SQ;
			BK_SQ:     state_d = BK_SQRT;
			BK_SQRT:   if (cnt_q == 5'd31) state_d = BK_DIV;
			BK_DIV:    if (cnt_q == 5'd0) state_d = BK_SCALE;
			BK_SCALE:  state_d = BK_CORNER;
			BK_CORNER: state_d = BK_EMIT;
			BK_EMIT:   if (can_load && emit_q == 3'd5) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// word to load into the output register
	always_comb begin
		load    = 1'b0;
		ld_x    = x2_q;
		ld_y    = y2_q;
		ld_kind = KIND_CAP;
		ld_last = 1'b0;
		unique case (state_q)
			BK_CAP: begin
				load    = can_load;
				ld_last = !flags_q.seg;
			end
			BK_EMIT: begin
				load    = can_load;
				ld_last = (emit_q == 3'd5);
				unique case (emit_q)
					3'd0: begin ld_x = lsx_q; ld_y = lsy_q; ld_kind = KIND_STITCH; end
					3'd1: begin ld_x = cax_q; ld_y = cay_q; ld_kind = KIND_STITCH; end
					3'd2: begin ld_x = cax_q; ld_y = cay_q; ld_kind = KIND_CORNER; end
					3'd3: begin ld_x = cbx_q; ld_y = cby_q; ld_kind = KIND_CORNER; end
					3'd4: begin ld_x = ccx_q; ld_y = ccy_q; ld_kind = KIND_CORNER; end
					default: begin ld_x = cdx_q; ld_y = cdy_q; ld_kind = KIND_CORNER; end
				endcase
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			strip_q     <= 1'b0;
			lsx_q       <= '0;
			lsy_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && job_flags.stk) begin
				strip_q <= 1'b0;
			end
			if (state_q == BK_EMIT && can_load && emit_q == 3'd5) begin
				strip_q <= 1'b1;
				lsx_q   <= cdx_q;
				lsy_q   <= cdy_q;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vx_q   <= ld_x;
			vy_q   <= ld_y;
			vk_q   <= ld_kind;
			zl_q   <= flags_q.zl;
			last_q <= ld_last;
		end
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					flags_q <= job_flags;
					x1_q    <= job_x1;
					y1_q    <= job_y1;
					x2_q    <= job_x2;
					y2_q    <= job_y2;
					sx_q    <= job_dx[COORD_BITS];
					sy_q    <= job_dy[COORD_BITS];
					ax_q    <= job_dx[COORD_BITS] ? MAG_W'(-job_dx) : MAG_W'(job_dx);
					ay_q    <= job_dy[COORD_BITS] ? MAG_W'(-job_dy) : MAG_W'(job_dy);
					co_q    <= '0;
					so_q    <= '0;
				end
			end
			BK_NORM: begin
				if (big) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (low_mag) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			BK_SQ: begin
				v_q   <= (64'(ax_q[15:0]) * 64'(ax_q[15:0]) +
				          64'(ay_q[15:0]) * 64'(ay_q[15:0])) << 30;
				r_q   <= '0;
				cnt_q <= 5'd0;
			end
			BK_SQRT: begin
				if (sq_ge) begin
					v_q <= v_q - sq_t;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				if (cnt_q == 5'd31) begin
					n_q    <= sq_ge ? 32'((r_q >> 1) + bitv) : 32'(r_q >> 1);
					remx_q <= 47'(ax_q[15:0]) << 30;
					remy_q <= 47'(ay_q[15:0]) << 30;
					cnt_q  <= 5'd16;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			BK_DIV: begin
				if (gex) remx_q <= 47'(49'(remx_q) - dsub);
				if (gey) remy_q <= 47'(49'(remy_q) - dsub);
				ux_q[cnt_q] <= gex;
				uy_q[cnt_q] <= gey;
				cnt_q <= cnt_q - 5'd1;
			end
			BK_SCALE: begin
				co_q <= sx_q ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
				so_q <= sy_q ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
			end
			BK_CORNER: begin
				cax_q  <= sat(x1w - sow - ecw);
				cay_q  <= sat(y1w + cow - esw);
				cbx_q  <= sat(x1w + sow - ecw);
				cby_q  <= sat(y1w - cow - esw);
				ccx_q  <= sat(x2w - sow + ecw);
				ccy_q  <= sat(y2w + cow + esw);
				cdx_q  <= sat(x2w + sow + ecw);
				cdy_q  <= sat(y2w - cow + esw);
				emit_q <= strip_q ? 3'd0 : 3'd2;
			end
			BK_EMIT: begin
				if (can_load) emit_q <= emit_q + 3'd1;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign vertex_x    = vx_q;
	assign vertex_y    = vy_q;
	assign vertex_kind = vk_q;
	assign zero_length = zl_q;
	assign last_of_run = last_q;

endmodule

@@ design/polyline_stroke_tessellator_top.sv @@
// Top level of the polyline stroke tessellator: config registers, front, queue, back.
//
// Input channel (in_valid / in_stall) takes one polyline point per word with
// its subpath_start and stroke_start flags. Output channel (out_valid /
// out_stall) gives vertex words: a cap point for every point, and for a point
// that closes a segment optionally two stitch words and then four strip corners.
// last_of_run marks the final word caused by a point.
// Sequence: a point without a segment occupies the back end for a pop and a cap
// word. A segment point runs through shift steps to normalize, a 32-step square
// root, a 17-step division (both components in parallel), then scaling, corner
// sums and four or six corner words.
// The front end and a two-entry queue keep taking points while the back works.
// Reset clears the previous point, the strip and the queue; half_width returns
// to 1.0 and square_cap to 0. When the receiver stalls the output word holds,
// the back end waits, and once the queue fills in_stall rises.
// Config writes through the APB port land at byte 0 (half_width) and byte 4
// (square_cap); pready is always high.
module polyline_stroke_tessellator_top import pst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         subpath_start,
	input  logic                         stroke_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic [1:0]                   vertex_kind,
	output logic                         zero_length,
	output logic                         last_of_run
);

	localparam int JOB_W = JOB_FLAGS_W + 4 * COORD_BITS + 2 * (COORD_BITS + 1);

	logic [15:0] half_width_q;
	logic        square_cap_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
			square_cap_q <= SQUARE_CAP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_HALF_WIDTH: half_width_q <= pwdata[15:0];
				REG_SQUARE_CAP: square_cap_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF_WIDTH: prdata = {16'd0, half_width_q};
			REG_SQUARE_CAP: prdata = {31'd0, square_cap_q};
			default:        prdata = '0;
		endcase
	end

	// front -> queue -> back
	logic                         q_full, q_push, q_valid, q_pop;
	job_flags_t                   f_flags, b_flags;
	logic signed [COORD_BITS-1:0] f_x1, f_y1, f_x2, f_y2, b_x1, b_y1, b_x2, b_y2;
	logic signed [COORD_BITS:0]   f_dx, f_dy, b_dx, b_dy;
	logic [JOB_W-1:0]             q_wdata, q_rdata;

	pst_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .point_x, .point_y,
		.subpath_start, .stroke_start, .q_full, .q_push,
		.job_flags(f_flags), .job_x1(f_x1), .job_y1(f_y1), .job_x2(f_x2),
		.job_y2(f_y2), .job_dx(f_dx), .job_dy(f_dy)
	);

	assign q_wdata = {f_flags, f_x1, f_y1, f_x2, f_y2, f_dx, f_dy};
	assign {b_flags, b_x1, b_y1, b_x2, b_y2, b_dx, b_dy} = q_rdata;

	pst_queue #(.W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .valid(q_valid), .rdata(q_rdata)
	);

	pst_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .half_width(half_width_q), .square_cap(square_cap_q),
		.q_valid, .q_pop, .job_flags(b_flags), .job_x1(b_x1), .job_y1(b_y1),
		.job_x2(b_x2), .job_y2(b_y2), .job_dx(b_dx), .job_dy(b_dy),
		.out_valid, .out_stall, .vertex_x, .vertex_y, .vertex_kind,
		.zero_length, .last_of_run
	);

	// a stitch word never ends a run
	a_stitch_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vertex_kind == KIND_STITCH |-> !last_of_run)
		else $error("stitch word marked last_of_run");

	// a cap that ends its run closed no segment, so it cannot be zero length
	a_lone_cap_no_zl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vertex_kind == KIND_CAP && last_of_run |-> !zero_length)
		else $error("lone cap flagged zero_length");

	// half_width write lands
	a_hw_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[2] == REG_HALF_WIDTH |=> half_width_q == $past(pwdata[15:0]))
		else $error("half_width write lost");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the polyline stroke tessellator top level.
`timescale 1ns / 1ps

module testbench;
	import pst_pkg::*;

	localparam int CB = 24;
	localparam int FB = 8;
	localparam longint SAT_HI = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic [1:0]           kind;
		logic                 zl;
		logic                 last;
	} vertex_t;

	// directed row: point and its subpath and stroke flags
	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 sub;
		logic                 stk;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CB-1:0] point_x = '0, point_y = '0;
	logic subpath_start = 0, stroke_start = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [CB-1:0] vertex_x, vertex_y;
	logic [1:0] vertex_kind;
	logic zero_length, last_of_run;

	// predictor state
	logic [15:0] m_half_width;
	logic        m_square_cap;
	longint      m_prev_x, m_prev_y, m_last_x, m_last_y;
	bit          m_have_prev, m_strip_full;

	vertex_t expected_vertices[$];
	int      errors = 0;
	int      cycles = 0;
	int      words_seen = 0;
	int      points_sent = 0;
	int      segments_seen = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_off = 0;

	polyline_stroke_tessellator_top u_top (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// compare each accepted vertex word with the oldest expectation
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{vertex_x, vertex_y, vertex_kind, zero_length, last_of_run};
			words_seen <= words_seen + 1;
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected vertex x=%0d y=%0d kind=%0d", $time,
					vertex_x, vertex_y, vertex_kind);
				errors <= errors + 1;
			end else begin
				want = expected_vertices.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected x=%0d y=%0d k=%0d zl=%0b l=%0b",
						$time, want.x, want.y, want.kind, want.zl, want.last);
					$display("%0t:          actual   x=%0d y=%0d k=%0d zl=%0b l=%0b",
						$time, got.x, got.y, got.kind, got.zl, got.last);
					errors <= errors + 1;
				end
			end
		end
	end

	function automatic longint clamp(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint scale_offset(longint unsigned u);
		int unsigned s = 23 - FB;
		longint unsigned p = u * m_half_width;
		return longint'((p + (64'd1 << (s - 1))) >> s);
	endfunction

	task automatic add_expected(longint x, longint y, vkind_t k, bit zl);
		vertex_t v;
		v.x = CB'(clamp(x));
		v.y = CB'(clamp(y));
		v.kind = k;
		v.zl = zl;
		v.last = 0;
		expected_vertices.insert(expected_vertices.size(), v);
	endtask

	// tessellate one point into expected vertex words
	task automatic tessellate(point_t p);
		longint x2 = p.x, y2 = p.y, x1 = m_prev_x, y1 = m_prev_y;
		longint dx, dy, co = 0, so = 0, ec, es;
		longint unsigned ax, ay, n;
		bit seg, zl;
		if (p.stk) m_strip_full = 0;
		seg = m_have_prev && !p.sub && !p.stk;
		dx = x2 - x1;
		dy = y2 - y1;
		zl = seg && dx == 0 && dy == 0;
		add_expected(x2, y2, KIND_CAP, zl);
		if (seg) begin
			if (!zl) begin
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				while (ax >= 65536 || ay >= 65536) begin
					ax >>= 1;
					ay >>= 1;
				end
				while (ax < 32768 && ay < 32768) begin
					ax <<= 1;
					ay <<= 1;
				end
				n = root64((ax * ax + ay * ay) << 30);
				if (n == 0) n = 1;
				co = scale_offset((ax << 30) / n);
				so = scale_offset((ay << 30) / n);
				if (dx < 0) co = -co;
				if (dy < 0) so = -so;
			end
			ec = m_square_cap ? co : 0;
			es = m_square_cap ? so : 0;
			if (m_strip_full) begin
				add_expected(m_last_x, m_last_y, KIND_STITCH, zl);
				add_expected(x1 - so - ec, y1 + co - es, KIND_STITCH, zl);
			end
			add_expected(x1 - so - ec, y1 + co - es, KIND_CORNER, zl);
			add_expected(x1 + so - ec, y1 - co - es, KIND_CORNER, zl);
			add_expected(x2 - so + ec, y2 + co + es, KIND_CORNER, zl);
			add_expected(x2 + so + ec, y2 - co + es, KIND_CORNER, zl);
			m_last_x = clamp(x2 + so + ec);
			m_last_y = clamp(y2 - co + es);
			m_strip_full = 1;
			segments_seen++;
		end
		expected_vertices[$].last = 1;
		m_prev_x = x2;
		m_prev_y = y2;
		m_have_prev = 1;
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr[2] == REG_HALF_WIDTH) m_half_width = data[15:0];
		else m_square_cap = data[0];
	endtask

	// one point word; predictor runs at the accepting edge
	task automatic send_point(point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		point_x <= p.x;
		point_y <= p.y;
		subpath_start <= p.sub;
		stroke_start <= p.stk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tessellate(p);
		points_sent++;
	endtask

	task automatic drain_then_idle();
		in_valid <= 0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CB-1:0] rand_coord(bit wide);
		if (wide) return CB'($urandom);
		return $signed(24'($urandom_range(8191))) - 24'sd4096;
	endfunction

	// well-formed strokes with random content, plus some stray flags
	task automatic random_points(int count);
		point_t p;
		int left = 0;
		bit wide;
		repeat (count) begin
			if (left == 0) begin
				left = $urandom_range(2, 8);
				p.stk = $urandom_range(3) != 0;
				p.sub = !p.stk;
				wide = $urandom_range(5) == 0;
			end else begin
				p.stk = $urandom_range(30) == 0;
				p.sub = $urandom_range(15) == 0;
			end
			left--;
			if (m_have_prev && $urandom_range(12) == 0) begin
				p.x = CB'(m_prev_x);
				p.y = CB'(m_prev_y);
			end else if (wide || $urandom_range(9) == 0) begin
				p.x = CB'($urandom);
				p.y = CB'($urandom);
			end else begin
				p.x = CB'(m_prev_x + rand_coord(0));
				p.y = CB'(m_prev_y + rand_coord(0));
			end
			send_point(p);
		end
	endtask

	localparam logic signed [CB-1:0] MAXC = 24'sh7FFFFF;
	localparam logic signed [CB-1:0] MINC = 24'sh800000;

	point_t directed[] = '{
		'{24'sd0, 24'sd0, 0, 0},          // first point: cap only
		'{24'sd2560, 24'sd0, 0, 0},       // horizontal segment
		'{24'sd2560, 24'sd2560, 0, 0},    // vertical, stitched
		'{24'sd2560, 24'sd2560, 0, 0},    // zero length
		'{-24'sd1000, -24'sd3000, 0, 0},  // negative deltas
		'{MAXC, MAXC, 0, 0},              // huge segment
		'{MAXC, MINC, 0, 0},              // saturating corners
		'{MINC, MINC, 0, 0},
		'{MINC, MAXC, 0, 0},
		'{24'sd5, 24'sd7, 1, 0},          // new sub-path
		'{24'sd6, 24'sd7, 0, 0},          // tiny delta, normalized up
		'{24'sd100, 24'sd100, 0, 1},      // new stroke empties strip
		'{24'sd300, 24'sd400, 0, 0},
		'{24'sd300, 24'sd400, 1, 1},      // both flags
		'{MAXC, MINC, 0, 0},
		'{MAXC, MINC, 0, 0}
	};

	initial begin
		vertex_t first_cap;
		m_half_width = HALF_WIDTH_RST;
		m_square_cap = SQUARE_CAP_RST;
		m_prev_x = 0; m_prev_y = 0; m_last_x = 0; m_last_y = 0;
		m_have_prev = 0; m_strip_full = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table at reset width, then at wide width with square caps, then at zero width without them
		for (int pass = 0; pass < 3; pass++) begin
			if (pass == 1) begin
				reg_write(3'd0, 32'hFFFF_FFFF);
				reg_write(3'd4, 32'hFFFF_FFFF);
			end else if (pass == 2) begin
				reg_write(3'd0, 32'd0);
				reg_write(3'd4, 32'd0);
			end
			for (int i = 0; i < directed.size(); i++) begin
				send_point(directed[i]);
				// first row of the first pass: cap at origin
				if (pass == 0 && i == 0) begin
					first_cap = '{24'sd0, 24'sd0, KIND_CAP, 1'b0, 1'b1};
					if (expected_vertices[$] !== first_cap) begin
						$display("%0t: predictor cap mismatch", $time);
						errors++;
					end
				end
			end
			drain_then_idle();
		end

		// random phases: settings and idle mixes vary
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				3: begin send_idle_pct = 14; recv_stall_pct = 14; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			reg_write(3'd0, (ph == 4) ? 32'd65535 : $urandom_range(65535));
			reg_write(3'd4, $urandom_range(1));
			if (ph == 4) hold_off = 3000;
			random_points(ph == 4 ? 62 : 80);
			drain_then_idle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		$display("covered %0d points, %0d segments, %0d vertex words", points_sent,
			segments_seen, words_seen);
		$display("widths 0..65535, both cap modes, idle and stall mixes, long hold-off");
		if (errors == 0 && expected_vertices.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d vertices missing", errors, expected_vertices.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
